// ===== sv/gwm_pkg.sv =====
`timescale 1ns / 1ps

package gwm_pkg;

    // Longest pattern the position chain supports.
    localparam int PATTERN_MAX = 32;

    // Pattern positions 0 .. PATTERN_MAX, one cell each.
    localparam int SET_W = PATTERN_MAX + 1;

    // Index into the position set; also carries the clamped pattern length.
    localparam int IDX_W = (SET_W > 1) ? $clog2(SET_W) : 1;

    // Field and register widths fixed by the register map.
    localparam int BYTE_W     = 8;
    localparam int PLEN_W     = 6;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Pattern bytes held in the byte registers.
    localparam int BYTES_PER_REG = CFG_DATA_W / BYTE_W;
    localparam int PAT_REGS      = 4;
    localparam int PAT_BYTES     = PAT_REGS * BYTES_PER_REG;

    localparam logic [BYTE_W-1:0] CH_ANY  = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;

    localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd4;

    // Per-request control broadcast to every cell of the chain.
    typedef struct packed {
        logic accept;
        logic has_byte;
        logic last;
    } gwm_ctrl_t;

endpackage

// ===== sv/glob_wildcard_matcher.sv =====
`timescale 1ns / 1ps
// Glob matcher: '?' any byte, '*' any run of bytes, one text byte per cycle while
// no result waits on m_ready. Throughput is one request per cycle unless a result is
// held; the position chain advances in the cycle a request is accepted. The result of
// a last request appears in the cycle after it is accepted, from the output register
// that holds the final position set; the star closure follows that register. Reset
// clears the pattern registers, leaves only position 0 reachable and clears the output valid flag.

module glob_wildcard_matcher (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [gwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gwm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [gwm_pkg::BYTE_W-1:0]     s_text_byte,
    input  logic                           s_has_byte,
    input  logic                           s_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_matched
);
    import gwm_pkg::*;

    logic [PLEN_W-1:0]     len_reg;
    logic [CFG_DATA_W-1:0] pat_reg [PAT_REGS];
    logic [IDX_W-1:0]      len_eff;
    gwm_ctrl_t             ctrl;
    logic [SET_W-1:0]      link_vec;
    logic [SET_W-1:0]      adv_vec;
    logic [SET_W-1:0]      star_vec;
    logic [SET_W-1:0]      snap_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            for (int i = 0; i < PAT_REGS; i++) begin
                pat_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LEN:  len_reg    <= cfg_wdata[PLEN_W-1:0];
                REG_PAT0: pat_reg[0] <= cfg_wdata;
                REG_PAT1: pat_reg[1] <= cfg_wdata;
                REG_PAT2: pat_reg[2] <= cfg_wdata;
                REG_PAT3: pat_reg[3] <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    assign len_eff = (len_reg > PLEN_W'(PATTERN_MAX)) ? IDX_W'(PATTERN_MAX)
                                                     : len_reg[IDX_W-1:0];

    assign s_ready       = !m_valid || m_ready;
    assign ctrl.accept   = s_valid && s_ready;
    assign ctrl.has_byte = s_has_byte;
    assign ctrl.last     = s_last;

    for (genvar p = 0; p < SET_W; p++) begin : g_cell
        logic [BYTE_W-1:0] pat_byte;
        logic              link_in;
        logic              adv_in;

        // Positions past the byte registers read as zero.
        if (p < PAT_BYTES) begin : g_pat
            assign pat_byte = pat_reg[p / BYTES_PER_REG][BYTE_W*(p % BYTES_PER_REG) +: BYTE_W];
        end else begin : g_nopat
            assign pat_byte = '0;
        end

        if (p == 0) begin : g_head
            assign link_in = 1'b0;
            assign adv_in  = 1'b0;
        end else begin : g_body
            assign link_in = link_vec[p-1];
            assign adv_in  = adv_vec[p-1];
        end

        gwm_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .text_byte   (s_text_byte),
            .pat_byte    (pat_byte),
            .active      (IDX_W'(p) < len_eff),
            .clear_value (p == 0),
            .link_in     (link_in),
            .adv_in      (adv_in),
            .link_out    (link_vec[p]),
            .adv_out     (adv_vec[p]),
            .star_out    (star_vec[p]),
            .snap_bit    (snap_vec[p])
        );
    end

    gwm_result u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (ctrl.accept && s_last),
        .set_in    (snap_vec),
        .star_mask (star_vec),
        .len_eff   (len_eff),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_matched (m_matched)
    );

    // The end position never has a pattern byte, so nothing leaves the chain.
    a_tail_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !link_vec[SET_W-1] && !adv_vec[SET_W-1])
        else $error("position chain drives past its end");

    a_last_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> m_valid)
        else $error("last request produced no result");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && !s_ready || m_ready))
        else $error("pending result lost or input taken over it");

endmodule

// ===== sv/gwm_cell.sv =====
`timescale 1ns / 1ps

module gwm_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  gwm_pkg::gwm_ctrl_t         ctrl,
    input  logic [gwm_pkg::BYTE_W-1:0] text_byte,
    input  logic [gwm_pkg::BYTE_W-1:0] pat_byte,
    input  logic                       active,
    input  logic                       clear_value,
    input  logic                       link_in,
    input  logic                       adv_in,
    output logic                       link_out,
    output logic                       adv_out,
    output logic                       star_out,
    output logic                       snap_bit
);
    import gwm_pkg::*;

    logic reach_reg;
    logic reach_next;
    logic closed;
    logic is_star;
    logic hit;
    logic step_bit;

    // A reachable star ahead of this position also makes it reachable.
    assign closed   = reach_reg | link_in;
    assign is_star  = active && (pat_byte == CH_STAR);
    assign hit      = active && !is_star && ((pat_byte == CH_ANY) || (pat_byte == text_byte));

    assign link_out = closed & is_star;
    assign adv_out  = closed & hit;
    assign star_out = is_star;

    // A star keeps its own position; a matching byte moves the neighbor on.
    assign step_bit = (closed & is_star) | adv_in;
    assign snap_bit = ctrl.has_byte ? step_bit : reach_reg;

    always_comb begin
        reach_next = reach_reg;
        if (ctrl.accept) begin
            reach_next = ctrl.last ? clear_value : snap_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reach_reg <= clear_value;
        end else begin
            reach_reg <= reach_next;
        end
    end

endmodule

// ===== sv/gwm_result.sv =====
`timescale 1ns / 1ps

module gwm_result (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  logic [gwm_pkg::SET_W-1:0] set_in,
    input  logic [gwm_pkg::SET_W-1:0] star_mask,
    input  logic [gwm_pkg::IDX_W-1:0] len_eff,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic                      m_matched
);
    import gwm_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [SET_W-1:0] fin_set_reg;
    logic [SET_W-1:0] fin_set_next;
    logic [SET_W-1:0] gen;
    logic [SET_W-1:0] sum;
    logic [SET_W-1:0] carry;
    logic [SET_W-1:0] closed;

    // Star closure as a carry chain: a set bit on a star generates, a star
    // propagates, and the carry into bit q marks q as reachable.
    assign gen    = fin_set_reg & star_mask;
    assign sum    = gen + star_mask;
    assign carry  = sum ^ gen ^ star_mask;
    assign closed = fin_set_reg | carry;

    assign m_valid   = valid_reg;
    assign m_matched = closed[len_eff];

    always_comb begin
        valid_next   = valid_reg;
        fin_set_next = fin_set_reg;
        if (load) begin
            valid_next   = 1'b1;
            fin_set_next = set_in;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fin_set_reg <= fin_set_next;
    end

endmodule

// ===== dv/glob_wildcard_matcher_tb.sv =====
`timescale 1ns / 1ps

module glob_wildcard_matcher_tb;

    import gwm_pkg::*;

    localparam int NUM_REGS   = 5;
    localparam int CLK_HALF   = 5;
    localparam int RESET_CYC  = 12;
    localparam int RAND_REQS  = 1000;
    localparam int SETTLE_CYC = 4;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              has_byte;
        logic              is_last;
    } text_req_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_text_byte;
    logic                  s_has_byte;
    logic                  s_last;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_matched;

    // Predictor copy of the configuration and the position set.
    logic [PLEN_W-1:0]     pat_len = '0;
    logic [CFG_DATA_W-1:0] pat_regs [PAT_REGS];
    logic [SET_W-1:0]      reach_set = 1;

    text_req_t text_req_q [$];
    logic      expected_match_q [$];

    int   mismatch_count = 0;
    int   req_total = 0;
    logic no_idle = 1'b0;
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    int   send_wait = 0;
    int   recv_wait = 0;
    logic stall_armed = 1'b0;

    glob_wildcard_matcher DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_text_byte(s_text_byte),
        .s_has_byte (s_has_byte),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_matched  (m_matched)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [BYTE_W-1:0] pat_at(int k);
        return pat_regs[k / BYTES_PER_REG][(k % BYTES_PER_REG) * BYTE_W +: BYTE_W];
    endfunction

    function automatic int eff_len();
        return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    endfunction

    // A reachable star also makes the next position reachable, chained.
    function automatic logic [SET_W-1:0] close_stars(logic [SET_W-1:0] s, int n);
        for (int p = 0; p < n; p++) begin
            if (s[p] && pat_at(p) == CH_STAR) begin
                s[p+1] = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic void match_step(text_req_t r);
        logic [SET_W-1:0] cur;
        logic [SET_W-1:0] nxt;
        logic [BYTE_W-1:0] b;
        int n;
        n = eff_len();
        if (r.has_byte) begin
            cur = close_stars(reach_set, n);
            nxt = '0;
            for (int p = 0; p < n; p++) begin
                if (cur[p]) begin
                    b = pat_at(p);
                    if (b == CH_STAR) begin
                        nxt[p] = 1'b1;
                    end else if (b == CH_ANY || b == r.text_byte) begin
                        nxt[p+1] = 1'b1;
                    end
                end
            end
            reach_set = nxt;
        end
        if (r.is_last) begin
            cur = close_stars(reach_set, n);
            expected_match_q.push_back(cur[n]);
            reach_set = 1;
        end
    endfunction

    function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_LEN:  pat_len = data[PLEN_W-1:0];
            REG_PAT0: pat_regs[0] = data;
            REG_PAT1: pat_regs[1] = data;
            REG_PAT2: pat_regs[2] = data;
            REG_PAT3: pat_regs[3] = data;
            default: ;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_text_byte();
        case ($urandom_range(0, 3))
            0: return "a";
            1: return "b";
            2: return CH_STAR;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_pattern_byte();
        case ($urandom_range(0, 9))
            0, 1:    return CH_STAR;
            2, 3:    return CH_ANY;
            4, 5, 6: return "a";
            7, 8:    return "b";
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_req(logic [BYTE_W-1:0] c, logic has, logic lst);
        text_req_t r;
        r.text_byte = c;
        r.has_byte  = has;
        r.is_last   = lst;
        text_req_q.push_back(r);
        req_total++;
    endtask

    // Queue a text; with finish and tail set, a byteless extra request closes it.
    task automatic send_bytes(logic [BYTE_W-1:0] t [$], logic finish, logic tail);
        for (int i = 0; i < t.size(); i++) begin
            add_req(t[i], 1'b1, finish && !tail && i == t.size() - 1);
        end
        if (finish && (tail || t.size() == 0)) begin
            add_req(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        model_write(idx, data);
    endtask

    task automatic end_cfg();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_pattern(logic [BYTE_W-1:0] pb [$], logic [CFG_DATA_W-1:0] len_word);
        logic [CFG_DATA_W-1:0] w [PAT_REGS];
        for (int r = 0; r < PAT_REGS; r++) begin
            w[r] = '0;
        end
        for (int i = 0; i < pb.size() && i < PAT_BYTES; i++) begin
            w[i / BYTES_PER_REG][(i % BYTES_PER_REG) * BYTE_W +: BYTE_W] = pb[i];
        end
        write_reg(REG_PAT0, w[0]);
        write_reg(REG_PAT1, w[1]);
        write_reg(REG_PAT2, w[2]);
        write_reg(REG_PAT3, w[3]);
        write_reg(REG_LEN, len_word);
        end_cfg();
    endtask

    // Wait until every request went out and every result came back, then let the
    // block finish whatever it still holds.
    task automatic settle();
        do begin
            @(posedge aclk);
        end while (text_req_q.size() != 0 || s_valid || expected_match_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic queue_random_text(logic finish);
        logic [BYTE_W-1:0] t [$];
        logic [BYTE_W-1:0] b;
        int n;
        int pos;
        n = eff_len();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(0, 6)) t.push_back(pick_text_byte());
        end else begin
            for (int p = 0; p < n; p++) begin
                b = pat_at(p);
                if (b == CH_STAR) begin
                    repeat ($urandom_range(0, 3)) t.push_back(pick_text_byte());
                end else if (b == CH_ANY) begin
                    t.push_back(pick_text_byte());
                end else begin
                    t.push_back(b);
                end
            end
            // Break a well-formed text now and then.
            if ($urandom_range(0, 3) == 0 && t.size() > 0) begin
                pos = $urandom_range(0, t.size() - 1);
                case ($urandom_range(0, 2))
                    0: t[pos] = pick_text_byte();
                    1: t.delete(pos);
                    default: t.insert(pos, pick_text_byte());
                endcase
            end
        end
        for (int i = 0; i < t.size(); i++) begin
            if ($urandom_range(0, 7) == 0) begin
                add_req(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            add_req(t[i], 1'b1, finish && i == t.size() - 1 && t.size() > 0 && 1'b0);
        end
        if (finish) begin
            if (t.size() > 0 && $urandom_range(0, 3) != 0) begin
                // Mark the final byte itself as the end of the text.
                text_req_q[text_req_q.size() - 1].is_last = 1'b1;
            end else begin
                add_req(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
        end
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] w;
        logic [PLEN_W-1:0] len;
        int mode;
        mode = $urandom_range(0, 4);
        for (int r = 0; r < PAT_REGS; r++) begin
            if (mode == 0) begin
                case ($urandom_range(0, 5))
                    0: w = '0;
                    1: w = '1;
                    default: w = {$urandom(), $urandom()};
                endcase
            end else begin
                for (int k = 0; k < BYTES_PER_REG; k++) begin
                    w[k * BYTE_W +: BYTE_W] = pick_pattern_byte();
                end
            end
            write_reg(REG_PAT0 + CFG_IDX_W'(r), w);
        end
        case ($urandom_range(0, 9))
            0: len = '0;
            1: len = PLEN_W'(PATTERN_MAX);
            2: len = PLEN_W'($urandom_range(PATTERN_MAX + 1, 63));
            default: len = PLEN_W'($urandom_range(1, 12));
        endcase
        if ($urandom_range(0, 2) == 0) begin
            w = {$urandom(), $urandom()};
            w[PLEN_W-1:0] = len;
        end else begin
            w = CFG_DATA_W'(len);
        end
        write_reg(REG_LEN, w);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 7)), {$urandom(), $urandom()});
        end
        end_cfg();
    endtask

    // Request side: one request at a time, with a random gap after each unless no_idle is set.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (send_wait > 0) begin
                s_valid   <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (text_req_q.size() > 0) begin
                s_valid     <= 1'b1;
                s_text_byte <= text_req_q[0].text_byte;
                s_has_byte  <= text_req_q[0].has_byte;
                s_last      <= text_req_q[0].is_last;
                void'(text_req_q.pop_front());
                send_wait   <= draw_wait();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: a fresh stall is drawn for each result as soon as it shows up.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (out_fire) begin
                stall_armed = 1'b0;
            end
            if (!m_valid) begin
                m_ready <= no_idle ? 1'b1 : 1'($urandom_range(0, 1));
            end else begin
                if (!stall_armed) begin
                    recv_wait   = draw_wait();
                    stall_armed = 1'b1;
                end
                if (recv_wait > 0) begin
                    m_ready   <= 1'b0;
                    recv_wait = recv_wait - 1;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        text_req_t r;
        logic expected;
        in_fire  <= aresetn && s_valid && s_ready;
        out_fire <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            r.text_byte = s_text_byte;
            r.has_byte  = s_has_byte;
            r.is_last   = s_last;
            match_step(r);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_match_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got matched=%0b",
                         $time, m_matched);
                mismatch_count++;
            end else begin
                expected = expected_match_q.pop_front();
                if (m_matched !== expected) begin
                    $display("%0t: matched mismatch, expected %0b, got %0b",
                             $time, expected, m_matched);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [BYTE_W-1:0] pb [$];
        for (int r = 0; r < PAT_REGS; r++) begin
            pat_regs[r] = '0;
        end
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_text_byte = '0;
        s_has_byte  = 1'b0;
        s_last      = 1'b0;
        m_ready     = 1'b0;
        repeat (RESET_CYC) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset pattern is empty: an empty text matches, a single byte does not.
        no_idle = 1'b1;
        add_req(8'h00, 1'b0, 1'b1);
        add_req(8'hFF, 1'b1, 1'b1);
        settle();

        no_idle = 1'b0;
        load_pattern('{"a", CH_ANY, CH_STAR, CH_STAR, "c"}, 5);
        send_bytes('{"a", CH_STAR, "c"}, 1'b1, 1'b0);
        send_bytes('{"a", "b", CH_STAR, "c"}, 1'b1, 1'b0);
        send_bytes('{"a", "b"}, 1'b1, 1'b1);
        settle();

        load_pattern('{8'h00, CH_ANY, 8'hFF}, 3);
        send_bytes('{8'h00, 8'h7A, 8'hFF}, 1'b1, 1'b0);
        // Leave a text open, then swap the pattern under it.
        send_bytes('{8'h00}, 1'b0, 1'b0);
        settle();
        load_pattern('{"b", CH_STAR}, 2);
        add_req(8'h55, 1'b0, 1'b1);
        settle();

        // Length beyond the supported maximum is clamped; the final byte decides.
        pb.delete();
        repeat (PATTERN_MAX - 1) pb.push_back(CH_STAR);
        pb.push_back("x");
        write_reg(CFG_IDX_W'(NUM_REGS), '1);
        write_reg(CFG_IDX_W'(7), '0);
        load_pattern(pb, '1);
        send_bytes('{"x"}, 1'b1, 1'b0);
        send_bytes('{"y"}, 1'b1, 1'b0);
        settle();

        while (req_total < RAND_REQS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            random_config();
            for (int count = req_total; req_total - count < 40; ) begin
                queue_random_text(1'b1);
            end
            if ($urandom_range(0, 4) == 0) begin
                queue_random_text(1'b0);
            end
            settle();
        end
        add_req(8'h00, 1'b0, 1'b1);
        settle();

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
